[sv/rbo_pkg.sv]
// ============================================================================
// Rider box overlap classifier package
// Shared types, codes and constants for the rider box overlap classifier.
// ============================================================================
`default_nettype none

package rbo_pkg;

  localparam int FIELD_W         = 12;
  localparam int MAX_BOXES_DEF   = 16;
  localparam int COORD_BITS_DEF  = 12;
  localparam int HEIGHT_W        = 12;
  localparam int HEIGHT_RESET    = 1080;
  localparam int THR_RESET       = HEIGHT_RESET / 6;
  localparam int RECIP_SIXTH     = 2731;
  localparam int RECIP_SHIFT     = 14;
  localparam int HCOUNT_W        = 5;
  localparam int HMASK_W         = 16;

  typedef enum logic [2:0] {
    FUNC_CLEAR = 3'd0,
    FUNC_ADD3  = 3'd1,
    FUNC_ADD2  = 3'd2,
    FUNC_ADDH  = 3'd3,
    FUNC_QUERY = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [FIELD_W-1:0] box_x;
    logic [FIELD_W-1:0] box_y;
    logic [FIELD_W-1:0] box_width;
    logic [FIELD_W-1:0] box_height;
  } in_t;

  typedef struct packed {
    logic                skipped;
    logic [1:0]          rider_count;
    logic                overload;
    logic [HCOUNT_W-1:0] helmet_count;
    logic [HMASK_W-1:0]  helmet_mask;
    logic                has_helmet;
  } out_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

[sv/rbo_overlap.sv]
// ============================================================================
// Box overlap test
// Checks two boxes with the half-of-smaller-side rule in both axes.
// ============================================================================
`default_nettype none

module rbo_overlap #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [4*COORD_BITS-1:0] box_a,
  input  wire logic [4*COORD_BITS-1:0] box_b,
  output logic                         hit
);

  localparam int S_W = COORD_BITS + 1;

  logic [COORD_BITS-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic [S_W-1:0]        a_xe, b_xe, a_ye, b_ye;
  logic [S_W-1:0]        x_end, y_end, x_lim, y_lim;
  logic [COORD_BITS-1:0] x_start, y_start, w_min, h_min;

  assign {ax, ay, aw, ah} = box_a;
  assign {bx, by, bw, bh} = box_b;

  assign a_xe = S_W'(ax) + S_W'(aw);
  assign b_xe = S_W'(bx) + S_W'(bw);
  assign a_ye = S_W'(ay) + S_W'(ah);
  assign b_ye = S_W'(by) + S_W'(bh);

  assign x_end   = (a_xe < b_xe) ? a_xe : b_xe;
  assign y_end   = (a_ye < b_ye) ? a_ye : b_ye;
  assign x_start = (ax > bx) ? ax : bx;
  assign y_start = (ay > by) ? ay : by;
  assign w_min   = (aw < bw) ? aw : bw;
  assign h_min   = (ah < bh) ? ah : bh;

  assign x_lim = S_W'(x_start) + S_W'(w_min >> 1);
  assign y_lim = S_W'(y_start) + S_W'(h_min >> 1);

  assign hit = (x_end > x_lim) && (y_end > y_lim);

endmodule

`default_nettype wire

[sv/rbo_cell.sv]
// ============================================================================
// Box table cell
// Holds one stored box and passes it to its neighbor while the ring turns.
// ============================================================================
`default_nettype none

module rbo_cell #(
  parameter int BOX_W = 48
) (
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic             load,
  input  wire logic [BOX_W-1:0] load_box,
  input  wire logic [BOX_W-1:0] neighbor_box,
  output logic      [BOX_W-1:0] box
);

  always_ff @(posedge clk) begin
    if (load) begin
      box <= load_box;
    end else if (shift) begin
      box <= neighbor_box;
    end
  end

endmodule

`default_nettype wire

[sv/rbo_table.sv]
// ============================================================================
// Box table ring
// A ring of cells with a fill count; one full turn presents every slot in
// order at the head and leaves the table as it was.
// ============================================================================
`default_nettype none

module rbo_table #(
  parameter int MAX_BOXES  = 16,
  parameter int COORD_BITS = 12,
  parameter int CNT_W      = $clog2(MAX_BOXES + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rbo_pkg::tbl_ctrl_t           ctrl,
  input  wire logic [4*COORD_BITS-1:0]      load_box,
  output logic      [4*COORD_BITS-1:0]      head_box,
  output logic      [CNT_W-1:0]             count
);

  import rbo_pkg::*;

  localparam int BOX_W = 4 * COORD_BITS;

  logic [BOX_W-1:0] cell_box [MAX_BOXES];
  logic             not_full;

  assign not_full = count < CNT_W'(MAX_BOXES);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
    end else if (ctrl.load && not_full) begin
      count <= count + CNT_W'(1);
    end
  end

  for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
    rbo_cell #(
      .BOX_W(BOX_W)
    ) u_cell (
      .clk         (clk),
      .shift       (ctrl.shift),
      .load        (ctrl.load && (count == CNT_W'(k))),
      .load_box    (load_box),
      .neighbor_box(cell_box[(k + 1) % MAX_BOXES]),
      .box         (cell_box[k])
    );
  end

  assign head_box = cell_box[0];

endmodule

`default_nettype wire

[sv/rider_box_overlap_classifier.sv]
// ============================================================================
// Rider box overlap classifier
// Keeps per-frame tables of three-person, two-person and helmet boxes and
// classifies rider boxes against them.
// ============================================================================
// Items enter on item_valid/item_stall and results leave on
// result_valid/result_stall; a transaction takes place on a clock edge with
// valid high and stall low. The cfg channel writes image_height and is always
// ready. Frame-start and load items give no result and leave item_stall low.
// A rider query rotates the three cell rings once, one slot per cycle through
// one overlap unit per table, then loads its result from ST_DONE; a box in the
// excluded top region skips the scan and goes straight to ST_DONE.
// item_stall stays high while a query is in flight. The result register lets
// the next item enter while a result waits; a finished query holds until the
// result register is free.
// Synchronous reset empties all tables, drops any pending result and sets
// image_height to 1080.
// ============================================================================
`default_nettype none

module rider_box_overlap_classifier #(
  parameter int MAX_BOXES  = rbo_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = rbo_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire rbo_pkg::in_t                 item,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output rbo_pkg::out_t                     result,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rbo_pkg::HEIGHT_W-1:0] cfg_data
);

  import rbo_pkg::*;

  localparam int BOX_W   = 4 * COORD_BITS;
  localparam int CNT_W   = $clog2(MAX_BOXES + 1);
  localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CMP_W   = (COORD_BITS + 1 > HEIGHT_W) ? COORD_BITS + 1 : HEIGHT_W;
  localparam int PROD_W  = 2 * HEIGHT_W;

  state_t                state, state_next;
  tbl_ctrl_t             ctrl3, ctrl2, ctrlh;
  logic                  start, scan_step, res_load;
  logic [HEIGHT_W-1:0]   threshold;
  logic [IDX_W-1:0]      idx;
  logic                  idx_last;
  logic [BOX_W-1:0]      rider, item_box;
  logic                  skip, skip_now;
  logic                  m3, m2;
  logic [HCOUNT_W-1:0]   hcount;
  logic [HMASK_W-1:0]    hmask;
  logic [BOX_W-1:0]      head3, head2, headh;
  logic [CNT_W-1:0]      cnt3, cnt2, cnth;
  logic                  ov3, ov2, ovh;
  logic                  hit3, hit2, hith;
  logic [1:0]            riders;
  logic [PROD_W-1:0]     thr_prod;

  assign item_box = {COORD_BITS'(item.box_x), COORD_BITS'(item.box_y),
                     COORD_BITS'(item.box_width), COORD_BITS'(item.box_height)};

  assign skip_now = (CMP_W'(COORD_BITS'(item.box_y)) + CMP_W'(COORD_BITS'(item.box_height)))
                    < CMP_W'(threshold);

  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign thr_prod   = PROD_W'(cfg_data) * PROD_W'(RECIP_SIXTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= HEIGHT_W'(THR_RESET);
    end else if (cfg_valid) begin
      threshold <= HEIGHT_W'(thr_prod >> RECIP_SHIFT);
    end
  end

  rbo_table #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS), .CNT_W(CNT_W)) u_tbl3 (
    .clk(clk), .rst(rst), .ctrl(ctrl3), .load_box(item_box), .head_box(head3), .count(cnt3)
  );
  rbo_table #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS), .CNT_W(CNT_W)) u_tbl2 (
    .clk(clk), .rst(rst), .ctrl(ctrl2), .load_box(item_box), .head_box(head2), .count(cnt2)
  );
  rbo_table #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS), .CNT_W(CNT_W)) u_tblh (
    .clk(clk), .rst(rst), .ctrl(ctrlh), .load_box(item_box), .head_box(headh), .count(cnth)
  );

  rbo_overlap #(.COORD_BITS(COORD_BITS)) u_ov3 (.box_a(rider), .box_b(head3), .hit(ov3));
  rbo_overlap #(.COORD_BITS(COORD_BITS)) u_ov2 (.box_a(rider), .box_b(head2), .hit(ov2));
  rbo_overlap #(.COORD_BITS(COORD_BITS)) u_ovh (.box_a(rider), .box_b(headh), .hit(ovh));

  assign hit3     = ov3 && (CNT_W'(idx) < cnt3);
  assign hit2     = ov2 && (CNT_W'(idx) < cnt2);
  assign hith     = ovh && (CNT_W'(idx) < cnth);
  assign idx_last = (idx == IDX_W'(MAX_BOXES - 1));

  assign riders = skip ? 2'd0 : (m3 ? 2'd3 : (m2 ? 2'd2 : 2'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl3      = '0;
    ctrl2      = '0;
    ctrlh      = '0;
    start      = 1'b0;
    scan_step  = 1'b0;
    res_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (item.func)
            FUNC_CLEAR: begin
              ctrl3.clear = 1'b1;
              ctrl2.clear = 1'b1;
              ctrlh.clear = 1'b1;
            end
            FUNC_ADD3: ctrl3.load = 1'b1;
            FUNC_ADD2: ctrl2.load = 1'b1;
            FUNC_ADDH: ctrlh.load = 1'b1;
            FUNC_QUERY: begin
              start      = 1'b1;
              state_next = skip_now ? ST_DONE : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ctrl3.shift = 1'b1;
        ctrl2.shift = 1'b1;
        ctrlh.shift = 1'b1;
        scan_step   = 1'b1;
        if (idx_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (start) begin
      idx <= '0;
    end else if (scan_step) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rider  <= item_box;
      skip   <= skip_now;
      m3     <= 1'b0;
      m2     <= 1'b0;
      hcount <= '0;
      hmask  <= '0;
    end else if (scan_step) begin
      m3 <= m3 || hit3;
      m2 <= m2 || hit2;
      if (hith && (hcount != '1)) begin
        hcount <= hcount + HCOUNT_W'(1);
      end
      if (hith) begin
        hmask <= hmask | (HMASK_W'(1) << idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.skipped      <= skip;
      result.rider_count  <= riders;
      result.overload     <= (riders == 2'd3);
      result.helmet_count <= skip ? '0 : hcount;
      result.helmet_mask  <= skip ? '0 : hmask;
      result.has_helmet   <= !skip && (hcount >= HCOUNT_W'(riders));
    end
  end

endmodule

`default_nettype wire

[sv/rbo_checker.sv]
// ============================================================================
// Rider box overlap classifier checker
// Port-level properties of the classifier, bound to the top level.
// ============================================================================
`default_nettype none

module rbo_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         item_valid,
  input wire logic                         item_stall,
  input wire rbo_pkg::in_t                 item,
  input wire logic                         result_valid,
  input wire logic                         result_stall,
  input wire rbo_pkg::out_t                result,
  input wire logic                         cfg_valid,
  input wire logic                         cfg_ready,
  input wire logic [rbo_pkg::HEIGHT_W-1:0] cfg_data
);

  import rbo_pkg::*;

  logic item_take;

  assign item_take = item_valid && !item_stall;

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_take && (item.func == FUNC_QUERY) |=> item_stall)
    else $error("A query transaction did not hold off the next item.");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    item_take && (item.func != FUNC_QUERY) |=> !item_stall)
    else $error("A non-query transaction kept the input stalled.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("A result appeared without a query in flight.");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("A stalled result changed or was dropped.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && (cfg_data != '0) |-> cfg_ready)
    else $error("A configuration write was refused.");

endmodule

bind rider_box_overlap_classifier rbo_checker u_rbo_checker (.*);

`default_nettype wire
